/* hdl/spac_pkg.sv */
`default_nettype none

package spac_pkg;

    // Default widths for the sample and per-phase counter
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 12;

    // Fixed register widths
    localparam int WINDOW_WIDTH    = 15;
    localparam int LIMIT_WIDTH     = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PHASE_WIDTH     = 3;

    // Register reset values
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_LOW_RESET  = 15'd8028;
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_HIGH_RESET = 15'd8684;
    localparam logic [LIMIT_WIDTH-1:0]  MAG_LIMIT_RESET   = 32'd75430363;
    localparam int                      SAMPLES_RESET     = 900;

    // Phase reached after the sixth orientation
    localparam logic [PHASE_WIDTH-1:0] DONE_PHASE = 3'd6;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_WINDOW_LOW,
        CFG_WINDOW_HIGH,
        CFG_MAG_LIMIT,
        CFG_SAMPLES
    } cfg_index_t;

endpackage

`default_nettype wire

/* hdl/six_position_accel_calibration_collector.sv */
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        to block   in_valid / in_stall   accel_x, accel_y, accel_z
// out       from block out_valid / out_stall accepted, phase_index, phase_complete,
//                                            average_x/y/z, all_complete
// cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item at a time. A plain item passes from acceptance to the load of the
// output register through three passes of the shared squarer (square, then
// accumulate), a check step and a load step; the next item is taken after the
// load. An item that finishes a phase adds three divisions on the shared
// serial divider and a step that advances the phase. Items after the sixth
// phase go straight to the load step.
// in_stall is high from acceptance until the result is loaded; the output
// register lets a new item be taken while the previous result waits.
// Reset clears the phase, count and sums and loads the register defaults.
module six_position_accel_calibration_collector
    import spac_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                accepted,
    output logic             [PHASE_WIDTH-1:0]  phase_index,
    output logic                                phase_complete,
    output logic signed      [SAMPLE_WIDTH-1:0] average_x,
    output logic signed      [SAMPLE_WIDTH-1:0] average_y,
    output logic signed      [SAMPLE_WIDTH-1:0] average_z,
    output logic                                all_complete,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic        [LIMIT_WIDTH-1:0]  cfg_data
);

    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int MAG_W = 2 * SAMPLE_WIDTH;
    localparam int CMP_W = (MAG_W > LIMIT_WIDTH) ? MAG_W : LIMIT_WIDTH;
    localparam int WIN_W = ((SAMPLE_WIDTH > WINDOW_WIDTH) ? SAMPLE_WIDTH : WINDOW_WIDTH) + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_CHECK,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH,
        S_EMIT
    } state_t;

    // Configuration registers
    logic [WINDOW_WIDTH-1:0] win_low_reg;
    logic [WINDOW_WIDTH-1:0] win_high_reg;
    logic [LIMIT_WIDTH-1:0]  mag_limit_reg;
    logic [COUNT_WIDTH-1:0]  samples_reg;

    // Sequencer and working state
    state_t                         state_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [SAMPLE_WIDTH-1:0] z_reg;
    logic [1:0]                     step_reg;
    logic [MAG_W-1:0]               prod_reg;
    logic [MAG_W-1:0]               mag_reg;
    logic signed [SUM_W-1:0]        sum_x_reg;
    logic signed [SUM_W-1:0]        sum_y_reg;
    logic signed [SUM_W-1:0]        sum_z_reg;
    logic [COUNT_WIDTH-1:0]         count_reg;
    logic [PHASE_WIDTH-1:0]         phase_reg;
    logic [1:0]                     div_axis_reg;

    // Result being built
    logic                           res_accepted_reg;
    logic [PHASE_WIDTH-1:0]         res_phase_reg;
    logic                           res_complete_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_avg_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_avg_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_avg_z_reg;
    logic                           res_all_reg;

    // Output register
    logic                           out_valid_reg;
    logic                           out_accepted_reg;
    logic [PHASE_WIDTH-1:0]         out_phase_reg;
    logic                           out_complete_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_avg_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_avg_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_avg_z_reg;
    logic                           out_all_reg;

    // Combinational helpers
    logic signed [SAMPLE_WIDTH-1:0] sq_op;
    logic signed [MAG_W-1:0]        sq_full;
    logic signed [SAMPLE_WIDTH-1:0] axis_sel;
    logic signed [WIN_W-1:0]        axis_w;
    logic signed [WIN_W-1:0]        lo_w;
    logic signed [WIN_W-1:0]        hi_w;
    logic                           win_ok;
    logic                           mag_ok;
    logic                           sample_ok;
    logic [COUNT_WIDTH-1:0]         count_inc;
    logic [COUNT_WIDTH-1:0]         target;
    logic                           reach;
    logic [PHASE_WIDTH-1:0]         phase_inc;
    logic signed [SUM_W-1:0]        div_dividend;
    logic                           div_start;
    logic                           div_done;
    logic [SAMPLE_WIDTH-1:0]        div_quotient;

    // Configuration port: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg   <= WINDOW_LOW_RESET;
            win_high_reg  <= WINDOW_HIGH_RESET;
            mag_limit_reg <= MAG_LIMIT_RESET;
            samples_reg   <= COUNT_WIDTH'(SAMPLES_RESET);
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_LOW:  win_low_reg   <= cfg_data[WINDOW_WIDTH-1:0];
                CFG_WINDOW_HIGH: win_high_reg  <= cfg_data[WINDOW_WIDTH-1:0];
                CFG_MAG_LIMIT:   mag_limit_reg <= cfg_data;
                CFG_SAMPLES:     samples_reg   <= cfg_data[COUNT_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // Shared squarer operand
    always_comb
    begin
        case (step_reg)
            2'd0:    sq_op = x_reg;
            2'd1:    sq_op = y_reg;
            default: sq_op = z_reg;
        endcase
    end

    assign sq_full = sq_op * sq_op;

    // Axis under test for the current phase
    always_comb
    begin
        case (phase_reg[2:1])
            2'd0:    axis_sel = x_reg;
            2'd1:    axis_sel = y_reg;
            default: axis_sel = z_reg;
        endcase
    end

    // Window test: (lo, hi) for up, (-hi, -lo) for down
    assign axis_w = WIN_W'(axis_sel);
    assign lo_w   = $signed(WIN_W'(win_low_reg));
    assign hi_w   = $signed(WIN_W'(win_high_reg));
    assign win_ok = phase_reg[0] ? ((axis_w < -lo_w) && (axis_w > -hi_w))
                                 : ((axis_w > lo_w) && (axis_w < hi_w));

    assign mag_ok    = (CMP_W'(mag_reg) < CMP_W'(mag_limit_reg));
    assign sample_ok = win_ok && mag_ok;

    // Phase completion: a zero setting counts as one
    assign count_inc = count_reg + 1'b1;
    assign target    = (samples_reg == '0) ? COUNT_WIDTH'(1) : samples_reg;
    assign reach     = (count_inc >= target);
    assign phase_inc = phase_reg + 1'b1;

    // Divider input
    always_comb
    begin
        case (div_axis_reg)
            2'd0:    div_dividend = sum_x_reg;
            2'd1:    div_dividend = sum_y_reg;
            default: div_dividend = sum_z_reg;
        endcase
    end

    assign div_start = (state_reg == S_DIV_START);

    spac_divider #(
        .DVD_W (SUM_W),
        .DVS_W (COUNT_WIDTH),
        .QUO_W (SAMPLE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            x_reg            <= '0;
            y_reg            <= '0;
            z_reg            <= '0;
            step_reg         <= '0;
            prod_reg         <= '0;
            mag_reg          <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_z_reg        <= '0;
            count_reg        <= '0;
            phase_reg        <= '0;
            div_axis_reg     <= '0;
            res_accepted_reg <= 1'b0;
            res_phase_reg    <= '0;
            res_complete_reg <= 1'b0;
            res_avg_x_reg    <= '0;
            res_avg_y_reg    <= '0;
            res_avg_z_reg    <= '0;
            res_all_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_accepted_reg <= 1'b0;
            out_phase_reg    <= '0;
            out_complete_reg <= 1'b0;
            out_avg_x_reg    <= '0;
            out_avg_y_reg    <= '0;
            out_avg_z_reg    <= '0;
            out_all_reg      <= 1'b0;
        end
        else
        begin
            // Result taken downstream; a reload in S_EMIT keeps it valid
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg         <= accel_x;
                        y_reg         <= accel_y;
                        z_reg         <= accel_z;
                        step_reg      <= '0;
                        mag_reg       <= '0;
                        res_avg_x_reg <= '0;
                        res_avg_y_reg <= '0;
                        res_avg_z_reg <= '0;
                        if (phase_reg >= DONE_PHASE)
                        begin
                            // Finished: reject without touching phase, count or sums
                            res_accepted_reg <= 1'b0;
                            res_phase_reg    <= DONE_PHASE;
                            res_complete_reg <= 1'b0;
                            res_all_reg      <= 1'b1;
                            state_reg        <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_SQUARE;
                        end
                    end
                end

                S_SQUARE:
                begin
                    prod_reg  <= sq_full;
                    state_reg <= S_ACCUM;
                end

                S_ACCUM:
                begin
                    mag_reg <= mag_reg + prod_reg;
                    if (step_reg == 2'd2)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_SQUARE;
                    end
                end

                S_CHECK:
                begin
                    res_accepted_reg <= sample_ok;
                    res_phase_reg    <= phase_reg;
                    res_complete_reg <= 1'b0;
                    res_all_reg      <= 1'b0;
                    state_reg        <= S_EMIT;
                    if (sample_ok)
                    begin
                        sum_x_reg <= sum_x_reg + SUM_W'(x_reg);
                        sum_y_reg <= sum_y_reg + SUM_W'(y_reg);
                        sum_z_reg <= sum_z_reg + SUM_W'(z_reg);
                        count_reg <= count_inc;
                        if (reach)
                        begin
                            res_complete_reg <= 1'b1;
                            div_axis_reg     <= '0;
                            state_reg        <= S_DIV_START;
                        end
                    end
                end

                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end

                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        case (div_axis_reg)
                            2'd0:    res_avg_x_reg <= div_quotient;
                            2'd1:    res_avg_y_reg <= div_quotient;
                            default: res_avg_z_reg <= div_quotient;
                        endcase
                        if (div_axis_reg == 2'd2)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            div_axis_reg <= div_axis_reg + 1'b1;
                            state_reg    <= S_DIV_START;
                        end
                    end
                end

                S_FINISH:
                begin
                    sum_x_reg   <= '0;
                    sum_y_reg   <= '0;
                    sum_z_reg   <= '0;
                    count_reg   <= '0;
                    phase_reg   <= phase_inc;
                    res_all_reg <= (phase_inc >= DONE_PHASE);
                    state_reg   <= S_EMIT;
                end

                S_EMIT:
                begin
                    // Load once the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_accepted_reg <= res_accepted_reg;
                        out_phase_reg    <= res_phase_reg;
                        out_complete_reg <= res_complete_reg;
                        out_avg_x_reg    <= res_avg_x_reg;
                        out_avg_y_reg    <= res_avg_y_reg;
                        out_avg_z_reg    <= res_avg_z_reg;
                        out_all_reg      <= res_all_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign accepted       = out_accepted_reg;
    assign phase_index    = out_phase_reg;
    assign phase_complete = out_complete_reg;
    assign average_x      = out_avg_x_reg;
    assign average_y      = out_avg_y_reg;
    assign average_z      = out_avg_z_reg;
    assign all_complete   = out_all_reg;

endmodule

`default_nettype wire

/* hdl/spac_divider.sv */
`default_nettype none

// Restoring divider: signed dividend by unsigned divisor, one quotient bit
// per cycle, truncated toward zero. done pulses one cycle with the quotient.
module spac_divider
    import spac_pkg::*;
#(
    parameter int DVD_W = SAMPLE_WIDTH_DEF + COUNT_WIDTH_DEF,
    parameter int DVS_W = COUNT_WIDTH_DEF,
    parameter int QUO_W = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DVD_W-1:0] dividend,
    input  wire logic        [DVS_W-1:0] divisor,
    output logic                         done,
    output logic             [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [QUO_W-1:0] quotient_reg;

    logic [DVD_W-1:0] dvd_mag;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic [DVD_W-1:0] quo_neg;

    // Magnitude of the dividend
    assign dvd_mag = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;

    // One restoring step: shift in the next dividend bit, try a subtract
    assign trial   = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = trial - {1'b0, dvs_reg};
    assign fits    = (trial >= {1'b0, dvs_reg});
    assign quo_neg = ~quo_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
            quo_reg      <= '0;
            rem_reg      <= '0;
            dvs_reg      <= '0;
            quotient_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            neg_reg  <= dividend[DVD_W-1];
            quo_reg  <= dvd_mag;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                // Restore the sign and keep the low bits
                busy_reg     <= 1'b0;
                done_reg     <= 1'b1;
                quotient_reg <= neg_reg ? quo_neg[QUO_W-1:0] : quo_reg[QUO_W-1:0];
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

`default_nettype wire
